// ===== hw/rtl/cossim_pkg.sv =====
package cossim_pkg;

   localparam int DOT_W       = 42;
   localparam int NORM_W      = 41;
   localparam int CNT_W       = 11;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int MAG_W       = DOT_W;
   localparam int WIDE_W      = 114;
   localparam int Q_W         = 15;
   localparam int K_W         = 4;
   localparam int STEP_W      = 6;
   localparam int RSHIFT      = 28;
   localparam int COUNT_LIMIT = 2047;

   localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a_elem;
      logic signed [ELEM_W-1:0] b_elem;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] similarity;
      logic                     zero_norm;
      logic                     too_long;
      logic [CNT_W-1:0]         length;
   } rsp_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
   } sums_type;

endpackage

// ===== hw/rtl/cosine_similarity.sv =====
// Cosine similarity of two streamed vectors.
// req: one element pair (a_elem, b_elem, signed Q1.15) per item, last marks
// the final pair. rsp: one item per vector pair with similarity (Q2.14,
// clamped to +-1.0), zero_norm, too_long and the pair count.
// For each pair one 16x16 multiplier forms a*a, b*b and a*b in turn and
// each product is added into its saturating sum; no further pair is
// taken meanwhile. Pairs beyond the length cap are only counted as too_long.
// After the last pair the result is formed by a shift-add multiply of the
// two norms, the square of |dot| and a 15-bit bit-by-bit search for the
// quotient, all on one shared 114-bit adder. If either norm is zero these
// steps are skipped.
// The result sits in an output register; the next vector's pairs are taken
// while it waits. A second result waits until the first has been taken.
// Reset clears all sums, the count and rsp_valid, not the output data.
module cosine_similarity #(
   parameter int MAX_DIM = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cossim_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cossim_pkg::rsp_type rsp_data
);
   import cossim_pkg::*;

   localparam int CAP = (MAX_DIM < COUNT_LIMIT) ? MAX_DIM : COUNT_LIMIT;
   localparam logic [CNT_W-1:0] LEN_CAP = CAP[CNT_W-1:0];

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MAC    = 3'd1;
   localparam logic [2:0] S_FINISH = 3'd2;
   localparam logic [2:0] S_RATIO  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic                     last_ff, last_in;
   logic [CNT_W-1:0]         pair_count_ff, pair_count_in;
   logic                     overflowed_ff, overflowed_in;
   logic signed [ELEM_W-1:0] sim_ff, sim_in;
   logic                     zn_ff, zn_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     accept, skip, emit, zero;
   logic                     mac_start, mac_done, ratio_start, ratio_done;
   sums_type                 sums;
   logic [Q_W-1:0]           q_mag;
   logic [ELEM_W-1:0]        q_ext;

   cossim_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .clear  (emit),
      .a_elem (req_data.a_elem),
      .b_elem (req_data.b_elem),
      .done   (mac_done),
      .sums   (sums)
   );

   cossim_ratio u_ratio (
      .clock (clock),
      .reset (reset),
      .start (ratio_start),
      .sums  (sums),
      .done  (ratio_done),
      .q_mag (q_mag)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign skip        = (pair_count_ff >= LEN_CAP);
   assign mac_start   = accept && !skip;
   assign zero        = (sums.norm_a == '0) || (sums.norm_b == '0);
   assign ratio_start = (state_ff == S_FINISH) && !zero;
   assign emit        = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign q_ext       = ELEM_W'(q_mag);

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      pair_count_in = pair_count_ff;
      overflowed_in = overflowed_ff;
      sim_in        = sim_ff;
      zn_in         = zn_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_data.last;
               if (skip) begin
                  overflowed_in = 1'b1;
                  if (req_data.last) begin
                     state_in = S_FINISH;
                  end
               end else begin
                  pair_count_in = pair_count_ff + 1'b1;
                  state_in      = S_MAC;
               end
            end
         end
         S_MAC: begin
            if (mac_done) begin
               state_in = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (zero) begin
               sim_in   = '0;
               zn_in    = 1'b1;
               state_in = S_EMIT;
            end else begin
               zn_in    = 1'b0;
               state_in = S_RATIO;
            end
         end
         S_RATIO: begin
            if (ratio_done) begin
               sim_in   = sums.dot[DOT_W-1] ? $signed(ELEM_W'(0) - q_ext) : $signed(q_ext);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit) begin
               rsp_in.similarity = sim_ff;
               rsp_in.zero_norm  = zn_ff;
               rsp_in.too_long   = overflowed_ff;
               rsp_in.length     = pair_count_ff;
               rsp_valid_in      = 1'b1;
               pair_count_in     = '0;
               overflowed_in     = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      sim_ff  <= sim_in;
      zn_ff   <= zn_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         pair_count_ff <= '0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pair_count_ff <= pair_count_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_mac_done_state: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == S_MAC)
      else $error("mac done outside accumulate state");

   a_ratio_done_state: assert property (@(posedge clock) disable iff (reset)
      ratio_done |-> state_ff == S_RATIO)
      else $error("ratio done outside ratio state");

   a_zero_norm_sim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_norm |-> rsp_data.similarity == 16'sd0)
      else $error("zero_norm with nonzero similarity");

   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.similarity <= 16'sd16384) &&
                    (rsp_data.similarity >= -16'sd16384) &&
                    (rsp_data.length <= LEN_CAP))
      else $error("result out of range");

endmodule

// ===== hw/rtl/cossim_mac.sv =====
module cossim_mac (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    clear,
   input  logic signed [cossim_pkg::ELEM_W-1:0]    a_elem,
   input  logic signed [cossim_pkg::ELEM_W-1:0]    b_elem,
   output logic                                    done,
   output cossim_pkg::sums_type                    sums
);
   import cossim_pkg::*;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_AA   = 3'd1;
   localparam logic [2:0] M_BB   = 3'd2;
   localparam logic [2:0] M_AB   = 3'd3;
   localparam logic [2:0] M_DOT  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [ELEM_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   sums_type                 sums_ff, sums_in;
   logic                     done_ff, done_in;

   logic signed [ELEM_W-1:0] mul_x, mul_y;
   logic [NORM_W-1:0]        norm_sel, norm_sat;
   logic [NORM_W:0]          norm_sum;
   logic signed [DOT_W:0]    dot_sum;
   logic signed [DOT_W-1:0]  dot_sat;

   always_comb begin
      unique case (state_ff)
         M_AA: begin
            mul_x = a_ff;
            mul_y = a_ff;
         end
         M_BB: begin
            mul_x = b_ff;
            mul_y = b_ff;
         end
         default: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
      endcase
      prod_in = mul_x * mul_y;

      norm_sel = (state_ff == M_BB) ? sums_ff.norm_a : sums_ff.norm_b;
      norm_sum = {1'b0, norm_sel} + {{(NORM_W + 1 - PROD_W){1'b0}}, prod_ff};
      norm_sat = norm_sum[NORM_W] ? {NORM_W{1'b1}} : norm_sum[NORM_W-1:0];

      dot_sum = {sums_ff.dot[DOT_W-1], sums_ff.dot}
              + {{(DOT_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
         dot_sat = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
      end else begin
         dot_sat = dot_sum[DOT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      sums_in  = sums_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (clear) begin
               sums_in = '0;
            end
            if (start) begin
               a_in     = a_elem;
               b_in     = b_elem;
               state_in = M_AA;
            end
         end
         M_AA: state_in = M_BB;
         M_BB: begin
            sums_in.norm_a = norm_sat;
            state_in       = M_AB;
         end
         M_AB: begin
            sums_in.norm_b = norm_sat;
            state_in       = M_DOT;
         end
         M_DOT: begin
            sums_in.dot = dot_sat;
            done_in     = 1'b1;
            state_in    = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= M_IDLE;
         sums_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sums_ff  <= sums_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign sums = sums_ff;

endmodule

// ===== hw/rtl/cossim_ratio.sv =====
module cossim_ratio (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  cossim_pkg::sums_type          sums,
   output logic                          done,
   output logic [cossim_pkg::Q_W-1:0]    q_mag
);
   import cossim_pkg::*;

   localparam logic [2:0] R_IDLE = 3'd0;
   localparam logic [2:0] R_MULN = 3'd1;
   localparam logic [2:0] R_MULR = 3'd2;
   localparam logic [2:0] R_SA   = 3'd3;
   localparam logic [2:0] R_SB   = 3'd4;
   localparam logic [2:0] R_SC   = 3'd5;
   localparam logic [2:0] R_DONE = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [WIDE_W-1:0] mcand_ff, mcand_in;
   logic [MAG_W-1:0]  mplier_ff, mplier_in;
   logic [WIDE_W-1:0] t_ff, t_in;
   logic [WIDE_W-1:0] ns_ff, ns_in;
   logic [WIDE_W-1:0] r_ff, r_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              ok_ff, ok_in;

   logic [WIDE_W-1:0] opa, opb, sum;
   logic [MAG_W-1:0]  dmag;
   logic              fits;

   // n = sa*sb, r = dot^2 << 28; then q is built MSB first from
   // P = q^2*n, Qs = q*n << (k+1), ns = n << 2k so that the test
   // (q + 2^k)^2*n <= r needs only adds and fixed shifts.
   always_comb begin
      dmag = sums.dot[DOT_W-1] ? (~sums.dot + 1'b1) : sums.dot;

      unique case (state_ff)
         R_MULN, R_MULR: begin
            opa = acc_ff;
            opb = mplier_ff[0] ? mcand_ff : '0;
         end
         R_SA: begin
            opa = acc_ff;
            opb = mcand_ff;
         end
         R_SB: begin
            opa = t_ff;
            opb = ns_ff;
         end
         default: begin
            opa = mcand_ff;
            opb = ok_ff ? (ns_ff << 1) : '0;
         end
      endcase
      sum  = opa + opb;
      fits = (sum <= r_ff);
   end

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      t_in      = t_ff;
      ns_in     = ns_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      ok_in     = ok_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               acc_in    = '0;
               mcand_in  = WIDE_W'(sums.norm_a);
               mplier_in = MAG_W'(sums.norm_b);
               cnt_in    = STEP_W'(NORM_W);
               state_in  = R_MULN;
            end
         end
         R_MULN: begin
            if (cnt_ff == STEP_W'(1)) begin
               ns_in     = sum << RSHIFT;
               acc_in    = '0;
               mcand_in  = WIDE_W'(dmag);
               mplier_in = dmag;
               cnt_in    = STEP_W'(MAG_W);
               state_in  = R_MULR;
            end else begin
               acc_in    = sum;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - 1'b1;
            end
         end
         R_MULR: begin
            if (cnt_ff == STEP_W'(1)) begin
               r_in     = sum << RSHIFT;
               acc_in   = '0;
               mcand_in = '0;
               q_in     = '0;
               k_in     = K_W'(Q_W - 1);
               state_in = R_SA;
            end else begin
               acc_in    = sum;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - 1'b1;
            end
         end
         R_SA: begin
            t_in     = sum;
            state_in = R_SB;
         end
         R_SB: begin
            ok_in = fits;
            if (fits) begin
               acc_in = sum;
               q_in   = q_ff | (Q_W'(1) << k_ff);
            end
            state_in = R_SC;
         end
         R_SC: begin
            mcand_in = sum >> 1;
            ns_in    = ns_ff >> 2;
            if (k_ff == '0) begin
               state_in = R_DONE;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = R_SA;
            end
         end
         R_DONE: state_in = R_IDLE;
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      t_ff      <= t_in;
      ns_ff     <= ns_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      ok_ff     <= ok_in;
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign done  = (state_ff == R_DONE);
   assign q_mag = (q_ff > ONE_Q14) ? ONE_Q14 : q_ff;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cossim_pkg::*;

   localparam int MAX_DIM        = 1024;
   localparam int LEN_CAP        = (MAX_DIM < COUNT_LIMIT) ? MAX_DIM : COUNT_LIMIT;
   localparam int LONG_STALL     = 400;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam longint DOT_HI  = (longint'(1) << (DOT_W - 1)) - 1;
   localparam longint DOT_LO  = -DOT_HI - 1;
   localparam longint NORM_HI = (longint'(1) << NORM_W) - 1;

   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

   typedef enum int {
      VEC_RANDOM,
      VEC_SAME,
      VEC_NEGATED,
      VEC_A_ZERO,
      VEC_B_ZERO,
      VEC_FULL_SCALE,
      VEC_OPPOSED
   } vec_shape_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit idle_en     = 1'b1;
   int stall_seq   = 0;
   int stall_seen  = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // running sums of the vector pair in flight
   logic signed [DOT_W-1:0]  acc_dot    = '0;
   logic        [NORM_W-1:0] acc_norm_a = '0;
   logic        [NORM_W-1:0] acc_norm_b = '0;
   logic        [CNT_W-1:0]  acc_count  = '0;
   logic                     acc_capped = 1'b0;

   rsp_type pending_results[$];

   cosine_similarity #(
      .MAX_DIM(MAX_DIM)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // largest q in [0, 1.0] with q^2 * na * nb <= dot^2 * 2^28
   function automatic logic [Q_W-1:0] cos_quotient(input logic [DOT_W-1:0] dot_mag,
                                                   input logic [NORM_W-1:0] na,
                                                   input logic [NORM_W-1:0] nb);
      logic [127:0] rhs;
      logic [127:0] norm_prod;
      logic [127:0] lhs;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      rhs       = (128'(dot_mag) * 128'(dot_mag)) << RSHIFT;
      norm_prod = 128'(na) * 128'(nb);
      lo = 0;
      hi = ONE_Q14;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = 128'(mid * mid) * norm_prod;
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return Q_W'(lo);
   endfunction

   function automatic void accumulate_pair(input req_type item);
      logic signed [31:0]      prod_ab;
      logic signed [31:0]      sq_a;
      logic signed [31:0]      sq_b;
      logic signed [DOT_W:0]   dot_next;
      logic        [NORM_W:0]  na_next;
      logic        [NORM_W:0]  nb_next;
      logic        [DOT_W-1:0] dot_mag;
      logic        [Q_W-1:0]   q;
      rsp_type                 res;
      if (acc_count >= LEN_CAP) begin
         acc_capped = 1'b1;
      end else begin
         prod_ab  = $signed(item.a_elem) * $signed(item.b_elem);
         sq_a     = $signed(item.a_elem) * $signed(item.a_elem);
         sq_b     = $signed(item.b_elem) * $signed(item.b_elem);
         dot_next = acc_dot + prod_ab;
         na_next  = acc_norm_a + $unsigned(sq_a);
         nb_next  = acc_norm_b + $unsigned(sq_b);
         if (dot_next > DOT_HI) begin
            acc_dot = DOT_W'(DOT_HI);
         end else if (dot_next < DOT_LO) begin
            acc_dot = DOT_W'(DOT_LO);
         end else begin
            acc_dot = dot_next[DOT_W-1:0];
         end
         acc_norm_a = (na_next > NORM_HI) ? NORM_W'(NORM_HI) : na_next[NORM_W-1:0];
         acc_norm_b = (nb_next > NORM_HI) ? NORM_W'(NORM_HI) : nb_next[NORM_W-1:0];
         acc_count  = acc_count + 1'b1;
      end
      if (!item.last) return;

      res = '0;
      if (acc_norm_a == '0 || acc_norm_b == '0) begin
         res.zero_norm = 1'b1;
      end else begin
         dot_mag = (acc_dot < 0) ? -acc_dot : acc_dot;
         q = cos_quotient(dot_mag, acc_norm_a, acc_norm_b);
         res.similarity = (acc_dot < 0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
      res.too_long = acc_capped;
      res.length   = acc_count;
      pending_results.push_back(res);

      acc_dot    = '0;
      acc_norm_a = '0;
      acc_norm_b = '0;
      acc_count  = '0;
      acc_capped = 1'b0;
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_error($sformatf("result with none expected: similarity=%0d length=%0d",
                                got.similarity, got.length));
         return;
      end
      want = pending_results.pop_front();
      if (got.similarity !== want.similarity)
         report_error($sformatf("similarity got %0d expected %0d",
                                got.similarity, want.similarity));
      if (got.zero_norm !== want.zero_norm)
         report_error($sformatf("zero_norm got %0b expected %0b",
                                got.zero_norm, want.zero_norm));
      if (got.too_long !== want.too_long)
         report_error($sformatf("too_long got %0b expected %0b",
                                got.too_long, want.too_long));
      if (got.length !== want.length)
         report_error($sformatf("length got %0d expected %0d", got.length, want.length));
   endtask

   // result side: check, then pick ready for the next cycle
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_seen != stall_seq) begin
            stall_seen = stall_seq;
            hold_left  = LONG_STALL - 1;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            hold_left  = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b,
                            input logic last);
      req_type item;
      item.a_elem = a;
      item.b_elem = b;
      item.last   = last;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      accumulate_pair(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0:       return ELEM_MIN;
         1:       return ELEM_MAX;
         2:       return ELEM_W'(int'($urandom_range(0, 31)) - 16);
         3:       return '0;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 95) return $urandom_range(9, 40);
      return $urandom_range(41, 200);
   endfunction

   function automatic vec_shape_type pick_shape();
      case ($urandom_range(0, 19))
         0:       return VEC_A_ZERO;
         1:       return VEC_B_ZERO;
         2:       return VEC_SAME;
         3:       return VEC_NEGATED;
         default: return VEC_RANDOM;
      endcase
   endfunction

   task automatic send_vector(input int len, input vec_shape_type shape);
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      for (int i = 0; i < len; i++) begin
         a = rand_elem();
         b = rand_elem();
         case (shape)
            VEC_SAME:       b = a;
            VEC_NEGATED:    b = -a;
            VEC_A_ZERO:     a = '0;
            VEC_B_ZERO:     b = '0;
            VEC_FULL_SCALE: begin
               a = ELEM_MIN;
               b = ELEM_MIN;
            end
            VEC_OPPOSED: begin
               a = ELEM_MIN;
               b = ELEM_MAX;
            end
            default: ;
         endcase
         send_pair(a, b, i == len - 1);
      end
   endtask

   task automatic test_directed_extremes();
      send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
      send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
      send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
      send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
      // zero magnitude on either side or both
      send_pair(16'sd0, 16'sd1234, 1'b1);
      send_pair(16'sd1234, 16'sd0, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd1, -16'sd1, 1'b1);
      // orthogonal
      send_pair(16'sd1, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd1, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd5, -16'sd3, 1'b1);
      send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
      send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
      send_pair(16'sd100, 16'sd200, 1'b0);
      send_pair(-16'sd300, 16'sd50, 1'b0);
      send_pair(16'sd7, -16'sd9, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_vectors(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = pick_length();
         send_vector(len, pick_shape());
         sent += len;
      end
   endtask

   // receiver holds off while short vectors keep coming, then sender waits
   task automatic test_output_stall();
      stall_seq++;
      for (int i = 0; i < 10; i++) send_vector($urandom_range(1, 4), pick_shape());
      wait_drained();
   endtask

   // past the cap with the last pairs dropped, then a short vector
   task automatic test_length_cap();
      send_vector(LEN_CAP + 2, VEC_OPPOSED);
      send_vector(2, VEC_FULL_SCALE);
      wait_drained();
   endtask

   task automatic test_no_idle();
      idle_en = 1'b0;
      test_random_vectors(100);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_vectors(180);
      test_output_stall();
      test_length_cap();
      test_no_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cossim_pkg.sv
hw/rtl/cossim_mac.sv
hw/rtl/cossim_ratio.sv
hw/rtl/cosine_similarity.sv
sim/tb_top.sv
